[rtl/circle_vertex_generator_defines.svh]
// assertion macros for the circle vertex generator checker
// no dependencies
`ifndef CIRCLE_VERTEX_GENERATOR_DEFINES_SVH
`define CIRCLE_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CVG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cvg check failed");

// next-cycle implication, disabled during reset
`define CVG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cvg check failed");

`endif

[rtl/cvg_pkg.sv]
// shared types, constants and helpers for the circle vertex generator
// no dependencies
`timescale 1ns / 1ps

package cvg_pkg;

  localparam int SEGMENTS = 100;
  localparam int IDX_W    = 10;
  localparam int SEG_W    = $clog2(SEGMENTS);
  localparam int IN_W     = 16;
  localparam int OUT_W    = 120;

  localparam logic [63:0] Q30         = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic signed [32:0] NEAR_EPS = 33'sd107374;

  typedef enum logic [2:0] {
    REG_CENTRE_X = 3'd0,
    REG_CENTRE_Y = 3'd1,
    REG_CENTRE_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_NORMAL_X = 3'd4,
    REG_NORMAL_Y = 3'd5,
    REG_NORMAL_Z = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] seg;
    logic [IDX_W-1:0] edge_end;
    logic             bad;
  } q_item_t;

  typedef struct packed {
    logic               ready;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
  } basis_t;

  // round to nearest by 2^30, ties away from zero
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] m;
    mag = v[65] ? 66'(-v) : 66'(v);
    m = (mag + 66'd536870912) >> 30;
    return v[65] ? 36'(-m) : 36'(m);
  endfunction

  // {sin, cos} in q2.30 for point i, only evaluated with constant i
  function automatic logic [63:0] trig_entry(input int unsigned i);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] tmp;
    logic        sw;
    logic [31:0] co;
    logic [31:0] si;
    q = 64'((4 * i) / SEGMENTS);
    r = 64'(4 * i) - q * 64'(SEGMENTS);
    sw = (2 * r) > 64'(SEGMENTS);
    if (sw) r = 64'(SEGMENTS) - r;
    x = (PI_HALF_Q30 * r + 64'(SEGMENTS / 2)) / 64'(SEGMENTS);
    x2 = (x * x) >> 30;
    s = Q30;
    s = Q30 - ((x2 * s) >> 30) / 72;
    s = Q30 - ((x2 * s) >> 30) / 42;
    s = Q30 - ((x2 * s) >> 30) / 20;
    s = Q30 - ((x2 * s) >> 30) / 6;
    s = (x * s) >> 30;
    c = Q30;
    c = Q30 - ((x2 * c) >> 30) / 90;
    c = Q30 - ((x2 * c) >> 30) / 56;
    c = Q30 - ((x2 * c) >> 30) / 30;
    c = Q30 - ((x2 * c) >> 30) / 12;
    c = Q30 - ((x2 * c) >> 30) / 2;
    if (sw) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    unique case (q[1:0])
      2'd0: begin co = c[31:0];       si = s[31:0];       end
      2'd1: begin co = 32'(-s[31:0]); si = c[31:0];       end
      2'd2: begin co = 32'(-c[31:0]); si = 32'(-s[31:0]); end
      default: begin co = s[31:0];    si = 32'(-c[31:0]); end
    endcase
    return {si, co};
  endfunction

endpackage

[rtl/cvg_front.sv]
// front end: accepts segment indexes, classifies them and queues them
// depends on cvg_pkg
`timescale 1ns / 1ps

module cvg_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [cvg_pkg::IN_W-1:0] s_tdata,   // [9:0] segment_index
  input  logic                    accept_en,
  input  logic                    zero_normal,
  input  logic                    pop,
  output cvg_pkg::q_item_t        head,
  output logic                    head_valid
);
  import cvg_pkg::*;

  q_item_t          ent [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             push;
  logic             do_pop;
  logic [IDX_W-1:0] idx;
  logic [IDX_W:0]   idx_inc;
  q_item_t          item;

  assign idx      = s_tdata[IDX_W-1:0];
  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign s_tready = accept_en && (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (cnt != 2'd0);

  always_comb begin
    item.bad = zero_normal || ({1'b0, idx} >= (IDX_W+1)'(SEGMENTS));
    item.seg = item.bad ? '0 : idx;
    if (item.bad || idx_inc >= (IDX_W+1)'(SEGMENTS)) begin
      item.edge_end = '0;
    end else begin
      item.edge_end = idx_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= item;
  end

  assign head       = ent[rd_ptr];
  assign head_valid = (cnt != 2'd0);

endmodule

[rtl/cvg_basis.sv]
// builds the unit normal, tangent and bitangent from the normal registers
// sequencer with one shared multiplier, square root and divider; depends on cvg_pkg
`timescale 1ns / 1ps

module cvg_basis (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  output cvg_pkg::basis_t    basis
);
  import cvg_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_MUL  = 7'b0000010,
    PH_ACC  = 7'b0000100,
    PH_RND  = 7'b0001000,
    PH_LOAD = 7'b0010000,
    PH_SQRT = 7'b0100000,
    PH_DIV  = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    ST_SUM_X  = 4'd0,
    ST_SUM_Y  = 4'd1,
    ST_SUM_Z  = 4'd2,
    ST_ROOT_N = 4'd3,
    ST_UX     = 4'd4,
    ST_UY     = 4'd5,
    ST_UZ     = 4'd6,
    ST_LEN_X  = 4'd7,
    ST_LEN_Y  = 4'd8,
    ST_ROOT_L = 4'd9,
    ST_TX     = 4'd10,
    ST_TY     = 4'd11,
    ST_BX     = 4'd12,
    ST_BY     = 4'd13,
    ST_BZ_A   = 4'd14,
    ST_BZ_B   = 4'd15
  } step_t;

  typedef enum logic [1:0] {
    KIND_MUL  = 2'd0,
    KIND_SQRT = 2'd1,
    KIND_DIV  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_SET = 2'd0,
    MODE_ADD = 2'd1,
    MODE_SUB = 2'd2,
    MODE_NEG = 2'd3
  } mode_t;

  function automatic kind_t kind_of(input step_t s);
    unique case (s)
      ST_ROOT_N, ST_ROOT_L:             return KIND_SQRT;
      ST_UX, ST_UY, ST_UZ, ST_TX, ST_TY: return KIND_DIV;
      default:                          return KIND_MUL;
    endcase
  endfunction

  phase_t phase;
  step_t  step;
  step_t  next_step;
  logic   last_iter;

  logic signed [65:0] prod;
  logic signed [65:0] acc;
  logic [31:0]        m;
  logic [31:0]        len;
  logic signed [31:0] u0, u1, u2, t0, t1, b0, b1, b2;

  logic [63:0] sq_v, sq_res, sq_bit;
  logic [63:0] sq_sum, sq_v_n, sq_res_n;
  logic [4:0]  sq_cnt;

  logic [61:0] dv_n;
  logic [31:0] dv_den, dv_rem, dv_q;
  logic        dv_neg;
  logic [5:0]  dv_cnt;
  logic [32:0] dv_sh;
  logic        dv_ge;
  logic [32:0] dv_rem_n;
  logic [31:0] dv_q_n;
  logic [31:0] dv_res;

  logic signed [32:0] op_a, op_b;
  mode_t              mode;
  logic signed [31:0] div_num;
  logic [31:0]        div_den;
  logic [31:0]        num_mag;
  logic signed [65:0] acc_n;
  logic signed [32:0] d_z_pos, d_z_neg;
  logic               near_z;
  logic               skip_t;

  always_comb begin
    op_a    = 33'(normal_x);
    op_b    = 33'(normal_x);
    mode    = MODE_SET;
    div_num = normal_x;
    div_den = m;
    unique case (step)
      ST_SUM_X: begin op_a = 33'(normal_x); op_b = 33'(normal_x); end
      ST_SUM_Y: begin op_a = 33'(normal_y); op_b = 33'(normal_y); mode = MODE_ADD; end
      ST_SUM_Z: begin op_a = 33'(normal_z); op_b = 33'(normal_z); mode = MODE_ADD; end
      ST_UX:    div_num = normal_x;
      ST_UY:    div_num = normal_y;
      ST_UZ:    div_num = normal_z;
      ST_LEN_X: begin op_a = 33'(u0); op_b = 33'(u0); end
      ST_LEN_Y: begin op_a = 33'(u1); op_b = 33'(u1); mode = MODE_ADD; end
      ST_TX:    begin div_num = u1; div_den = len; end
      ST_TY:    begin div_num = 32'(-u0); div_den = len; end
      ST_BX:    begin op_a = 33'(u2); op_b = 33'(t1); mode = MODE_NEG; end
      ST_BY:    begin op_a = 33'(u2); op_b = 33'(t0); end
      ST_BZ_A:  begin op_a = 33'(u0); op_b = 33'(t1); end
      ST_BZ_B:  begin op_a = 33'(u1); op_b = 33'(t0); mode = MODE_SUB; end
      default: ;
    endcase
  end

  always_comb begin
    unique case (mode)
      MODE_SET: acc_n = prod;
      MODE_ADD: acc_n = acc + prod;
      MODE_SUB: acc_n = acc - prod;
      default:  acc_n = -prod;
    endcase
  end

  // square root step, one result bit per iteration
  always_comb begin
    sq_sum = sq_res + sq_bit;
    if (sq_v >= sq_sum) begin
      sq_v_n   = sq_v - sq_sum;
      sq_res_n = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_n   = sq_v;
      sq_res_n = sq_res >> 1;
    end
  end

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    dv_sh    = {dv_rem, dv_n[61]};
    dv_ge    = dv_sh >= {1'b0, dv_den};
    dv_rem_n = dv_ge ? (dv_sh - {1'b0, dv_den}) : dv_sh;
    dv_q_n   = {dv_q[30:0], dv_ge};
    dv_res   = dv_neg ? 32'(-dv_q_n) : dv_q_n;
  end

  assign num_mag = div_num[31] ? 32'(-div_num) : 32'(div_num);
  assign d_z_pos = 33'(u2) - 33'sd1073741824;
  assign d_z_neg = 33'(u2) + 33'sd1073741824;

  always_comb begin
    near_z = (33'(u0) <= NEAR_EPS) && (33'(u0) >= -NEAR_EPS)
          && (33'(u1) <= NEAR_EPS) && (33'(u1) >= -NEAR_EPS)
          && (((d_z_pos <= NEAR_EPS) && (d_z_pos >= -NEAR_EPS))
           || ((d_z_neg <= NEAR_EPS) && (d_z_neg >= -NEAR_EPS)));
    skip_t = near_z || (sq_res_n[31:0] == 32'd0);
  end

  always_comb begin
    last_iter = 1'b0;
    unique case (phase)
      PH_RND:  last_iter = 1'b1;
      PH_SQRT: last_iter = (sq_cnt == 5'd31);
      PH_DIV:  last_iter = (dv_cnt == 6'd61);
      default: last_iter = 1'b0;
    endcase
    if (phase == PH_SQRT && step == ST_ROOT_L && skip_t) begin
      next_step = ST_BX;
    end else begin
      next_step = step_t'(step + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      phase <= PH_MUL;
      step  <= ST_SUM_X;
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_MUL:  phase <= PH_ACC;
        PH_ACC:  phase <= PH_RND;
        PH_LOAD: phase <= (kind_of(step) == KIND_SQRT) ? PH_SQRT : PH_DIV;
        default: begin
          if (last_iter) begin
            if (step == ST_BZ_B) begin
              phase <= PH_IDLE;
            end else begin
              step  <= next_step;
              phase <= (kind_of(next_step) == KIND_MUL) ? PH_MUL : PH_LOAD;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      PH_MUL: prod <= op_a * op_b;
      PH_ACC: acc <= acc_n;
      PH_RND: begin
        if (step == ST_BX) b0 <= 32'(rnd30(acc));
        if (step == ST_BY) b1 <= 32'(rnd30(acc));
        if (step == ST_BZ_B) b2 <= 32'(rnd30(acc));
      end
      PH_LOAD: begin
        sq_v   <= acc[63:0];
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
        sq_cnt <= '0;
        dv_n   <= {num_mag, 30'd0} + 62'(div_den >> 1);
        dv_den <= div_den;
        dv_rem <= '0;
        dv_q   <= '0;
        dv_neg <= div_num[31];
        dv_cnt <= '0;
      end
      PH_SQRT: begin
        sq_v   <= sq_v_n;
        sq_res <= sq_res_n;
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 5'd1;
        if (last_iter) begin
          if (step == ST_ROOT_N) m <= sq_res_n[31:0];
          if (step == ST_ROOT_L) begin
            len <= sq_res_n[31:0];
            if (skip_t) begin
              t0 <= 32'sd1073741824;
              t1 <= '0;
            end
          end
        end
      end
      PH_DIV: begin
        dv_n   <= dv_n << 1;
        dv_rem <= dv_rem_n[31:0];
        dv_q   <= dv_q_n;
        dv_cnt <= dv_cnt + 6'd1;
        if (last_iter) begin
          if (step == ST_UX) u0 <= dv_res;
          if (step == ST_UY) u1 <= dv_res;
          if (step == ST_UZ) u2 <= dv_res;
          if (step == ST_TX) t0 <= dv_res;
          if (step == ST_TY) t1 <= dv_res;
        end
      end
      default: ;
    endcase
  end

  assign basis.ready = (phase == PH_IDLE);
  assign basis.t0    = t0;
  assign basis.t1    = t1;
  assign basis.b0    = b0;
  assign basis.b1    = b1;
  assign basis.b2    = b2;

endmodule

[rtl/cvg_back.sv]
// back end: angle lookup, rotation into the circle plane, scale and offset
// five-stage pipeline ending in the output register; depends on cvg_pkg
`timescale 1ns / 1ps

module cvg_back (
  input  logic                      clk,
  input  logic                      rst,
  input  cvg_pkg::q_item_t          head,
  input  logic                      head_valid,
  output logic                      pop,
  input  cvg_pkg::basis_t           basis,
  input  logic signed [31:0]        centre_x,
  input  logic signed [31:0]        centre_y,
  input  logic signed [31:0]        centre_z,
  input  logic [30:0]               radius,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [cvg_pkg::OUT_W-1:0] m_tdata,  // vertex_x, vertex_y, vertex_z, edge_start, edge_end
  output logic                      m_tuser   // bad_request
);
  import cvg_pkg::*;

  localparam logic signed [36:0] VMAX = 37'sd2147483647;
  localparam logic signed [36:0] VMIN = -37'sd2147483648;

  logic [63:0] trig [2**SEG_W];

  for (genvar g = 0; g < 2**SEG_W; g++) begin : g_trig
    if (g < SEGMENTS) begin : g_on
      assign trig[g] = trig_entry(g);
    end else begin : g_off
      assign trig[g] = '0;
    end
  end

  logic               en;
  logic [4:0]         v;
  q_item_t            meta [4];
  logic signed [31:0] co, si;
  logic signed [31:0] tv [3];
  logic signed [31:0] bv [3];
  logic signed [31:0] cv [3];
  logic signed [63:0] pc [3];
  logic signed [63:0] ps [3];
  logic signed [32:0] w  [3];
  logic signed [64:0] pr [3];
  logic signed [31:0] vtx [3];
  logic signed [36:0] vs  [3];
  logic signed [31:0] vsat [3];
  q_item_t            out_meta;

  assign en  = !v[4] || m_tready;
  assign pop = en && head_valid;

  assign tv[0] = basis.t0;
  assign tv[1] = basis.t1;
  assign tv[2] = '0;
  assign bv[0] = basis.b0;
  assign bv[1] = basis.b1;
  assign bv[2] = basis.b2;
  assign cv[0] = centre_x;
  assign cv[1] = centre_y;
  assign cv[2] = centre_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], head_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vs[k] = 37'(cv[k]) + 37'(rnd30(66'(pr[k])));
      if (vs[k] > VMAX) begin
        vsat[k] = 32'sh7FFF_FFFF;
      end else if (vs[k] < VMIN) begin
        vsat[k] = 32'sh8000_0000;
      end else begin
        vsat[k] = 32'(vs[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[0]  <= head;
      co       <= trig[head.seg[SEG_W-1:0]][31:0];
      si       <= trig[head.seg[SEG_W-1:0]][63:32];
      meta[1]  <= meta[0];
      meta[2]  <= meta[1];
      meta[3]  <= meta[2];
      out_meta <= meta[3];
      for (int k = 0; k < 3; k++) begin
        pc[k]  <= co * tv[k];
        ps[k]  <= si * bv[k];
        w[k]   <= 33'(rnd30(66'(pc[k]) + 66'(ps[k])));
        pr[k]  <= $signed({1'b0, radius}) * w[k];
        vtx[k] <= meta[3].bad ? '0 : vsat[k];
      end
    end
  end

  assign m_tvalid = v[4];
  assign m_tuser  = out_meta.bad;
  assign m_tdata  = {4'd0, out_meta.edge_end, out_meta.seg, vtx[2], vtx[1], vtx[0]};

endmodule

[rtl/circle_vertex_generator.sv]
// circle vertex generator: one outline point and edge per segment index
// channels: s_* takes a segment index, m_* returns the point, edge and a flag
// cfg_* writes centre, radius and normal registers by index (0..6), any time the
// block is idle; the write is always taken and index 7 is ignored
// after reset or any register write the basis sequencer rebuilds the unit normal,
// tangent and bitangent (the divisions dominate the time it takes); s_tready stays
// low until it is done
// then one item per cycle is accepted, unless a stall on m_tready fills the queue
// zero normal or index >= SEGMENTS gives a result with m_tuser high and zero data
// a stall on m_tready holds the output register and fills the 2-entry queue
// behind it, then drops s_tready; nothing is lost
// depends on cvg_pkg, cvg_front, cvg_basis, cvg_back
`timescale 1ns / 1ps

module circle_vertex_generator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [cvg_pkg::IN_W-1:0]  s_tdata,   // [9:0] segment_index
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [cvg_pkg::OUT_W-1:0] m_tdata,   // vertex_x, vertex_y, vertex_z, edge_start, edge_end
  output logic                      m_tuser,   // bad_request
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import cvg_pkg::*;

  logic signed [31:0] centre_x, centre_y, centre_z;
  logic [30:0]        radius;
  logic signed [31:0] normal_x, normal_y, normal_z;
  basis_t             basis;
  q_item_t            head;
  logic               head_valid;
  logic               pop;
  logic               zero_normal;

  assign cfg_ready   = 1'b1;
  assign zero_normal = (normal_x == '0) && (normal_y == '0) && (normal_z == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x <= '0;
      centre_y <= '0;
      centre_z <= '0;
      radius   <= 31'd65536;
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= 32'sd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTRE_X: centre_x <= cfg_data;
        REG_CENTRE_Y: centre_y <= cfg_data;
        REG_CENTRE_Z: centre_z <= cfg_data;
        REG_RADIUS:   radius   <= cfg_data[30:0];
        REG_NORMAL_X: normal_x <= cfg_data;
        REG_NORMAL_Y: normal_y <= cfg_data;
        REG_NORMAL_Z: normal_z <= cfg_data;
        default: ;
      endcase
    end
  end

  cvg_basis u_basis (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_valid),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .basis    (basis)
  );

  cvg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .accept_en   (basis.ready && !cfg_valid),
    .zero_normal (zero_normal),
    .pop         (pop),
    .head        (head),
    .head_valid  (head_valid)
  );

  cvg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .basis      (basis),
    .centre_x   (centre_x),
    .centre_y   (centre_y),
    .centre_z   (centre_z),
    .radius     (radius),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

[rtl/cvg_checker.sv]
// port-level checks on the circle vertex generator result channel
// depends on cvg_pkg and circle_vertex_generator_defines.svh; bound to the top level
`timescale 1ns / 1ps
`include "circle_vertex_generator_defines.svh"

module cvg_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [cvg_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser
);
  import cvg_pkg::*;

  `CVG_ASSERT_NXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `CVG_ASSERT_IMP(a_bad_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  `CVG_ASSERT_IMP(a_edge_range, clk, rst, m_tvalid && !m_tuser, m_tdata[105:96] < 10'(SEGMENTS))
  `CVG_ASSERT_IMP(a_edge_wrap, clk, rst, m_tvalid && !m_tuser, (m_tdata[105:96] == 10'(SEGMENTS - 1)) ? (m_tdata[115:106] == 10'd0) : (m_tdata[115:106] == m_tdata[105:96] + 10'd1))

endmodule

bind circle_vertex_generator cvg_checker u_cvg_checker (.*);

[bench/testbench.sv]
// self-checking testbench for circle_vertex_generator: directed and random segment
// indices over several circle settings, with a bit-exact vertex predictor
// depends on cvg_pkg and the circle_vertex_generator rtl
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] vx;
  logic [31:0] vy;
  logic [31:0] vz;
  logic [9:0]  e_start;
  logic [9:0]  e_end;
  logic        bad;
} vertex_t;

class vertex_board;
  longint  regs[7];
  vertex_t pending_q[$];
  int      errors;

  function new();
    errors = 0;
    for (int k = 0; k < 7; k++) regs[k] = 0;
    regs[cvg_pkg::REG_RADIUS] = 65536;
    regs[cvg_pkg::REG_NORMAL_Z] = 65536;
  endfunction

  function void set_reg(int idx, logic [31:0] d);
    if (idx == cvg_pkg::REG_RADIUS) regs[idx] = longint'({33'd0, d[30:0]});
    else regs[idx] = longint'(signed'(d));
  endfunction

  static function longint unsigned amag(longint v);
    return v < 0 ? -v : v;
  endfunction

  static function longint unsigned isq(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  static function longint div_rnd(longint num, longint unsigned den);
    longint unsigned m;
    m = (amag(num) + den / 2) / den;
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  static function longint rnd30(longint v);
    longint unsigned m;
    m = (amag(v) + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  static function longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function vertex_t predict(logic [9:0] idx);
    localparam longint ONE = 64'sd1073741824;
    localparam longint EPS = 64'sd107374;
    vertex_t e;
    longint unsigned sum, m, len, q, r, x, x2, s, c, tmp;
    longint u[3], t[3], b[3], co, si, w;
    int segs;
    bit swap;
    segs = cvg_pkg::SEGMENTS;
    sum = amag(regs[4]) * amag(regs[4]) + amag(regs[5]) * amag(regs[5])
        + amag(regs[6]) * amag(regs[6]);
    e = '{default: 0};
    if (sum == 0 || idx >= segs) begin
      e.bad = 1;
      return e;
    end
    m = isq(sum);
    for (int k = 0; k < 3; k++) u[k] = div_rnd(regs[4+k] * ONE, m);
    len = isq(amag(u[0]) * amag(u[0]) + amag(u[1]) * amag(u[1]));
    if ((amag(u[0]) <= EPS && amag(u[1]) <= EPS &&
         (amag(u[2] - ONE) <= EPS || amag(u[2] + ONE) <= EPS)) || len == 0) begin
      t[0] = ONE; t[1] = 0; t[2] = 0;
    end else begin
      t[0] = div_rnd(u[1] * ONE, len);
      t[1] = div_rnd(-u[0] * ONE, len);
      t[2] = 0;
    end
    b[0] = rnd30(u[1] * t[2] - u[2] * t[1]);
    b[1] = rnd30(u[2] * t[0] - u[0] * t[2]);
    b[2] = rnd30(u[0] * t[1] - u[1] * t[0]);
    q = (4 * idx) / segs;
    r = 4 * idx - q * segs;
    swap = 2 * r > segs;
    if (swap) r = segs - r;
    x = (64'd1686629713 * r + segs / 2) / segs;
    x2 = (x * x) >> 30;
    s = ONE;
    s = ONE - ((x2 * s) >> 30) / 72;
    s = ONE - ((x2 * s) >> 30) / 42;
    s = ONE - ((x2 * s) >> 30) / 20;
    s = ONE - ((x2 * s) >> 30) / 6;
    s = (x * s) >> 30;
    c = ONE;
    c = ONE - ((x2 * c) >> 30) / 90;
    c = ONE - ((x2 * c) >> 30) / 56;
    c = ONE - ((x2 * c) >> 30) / 30;
    c = ONE - ((x2 * c) >> 30) / 12;
    c = ONE - ((x2 * c) >> 30) / 2;
    if (swap) begin
      tmp = s; s = c; c = tmp;
    end
    case (q & 3)
      0: begin co = c; si = s; end
      1: begin co = -longint'(s); si = c; end
      2: begin co = -longint'(c); si = -longint'(s); end
      default: begin co = s; si = -longint'(c); end
    endcase
    w = rnd30(co * t[0] + si * b[0]);
    e.vx = 32'(sat(regs[0] + rnd30(regs[3] * w)));
    w = rnd30(co * t[1] + si * b[1]);
    e.vy = 32'(sat(regs[1] + rnd30(regs[3] * w)));
    w = rnd30(co * t[2] + si * b[2]);
    e.vz = 32'(sat(regs[2] + rnd30(regs[3] * w)));
    e.e_start = idx;
    e.e_end = (idx + 1 >= segs) ? 10'd0 : idx + 10'd1;
    return e;
  endfunction

  function void note(logic [9:0] idx);
    pending_q.insert(pending_q.size(), predict(idx));
  endfunction

  function void check(logic [119:0] d, logic bad);
    vertex_t e;
    if (pending_q.size() == 0) begin
      $error("result item with no expectation: data %h bad %b", d, bad);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (d[31:0] !== e.vx) begin
      $error("vertex_x expected %h actual %h", e.vx, d[31:0]); errors++;
    end
    if (d[63:32] !== e.vy) begin
      $error("vertex_y expected %h actual %h", e.vy, d[63:32]); errors++;
    end
    if (d[95:64] !== e.vz) begin
      $error("vertex_z expected %h actual %h", e.vz, d[95:64]); errors++;
    end
    if (d[105:96] !== e.e_start) begin
      $error("edge_start expected %0d actual %0d", e.e_start, d[105:96]); errors++;
    end
    if (d[115:106] !== e.e_end) begin
      $error("edge_end expected %0d actual %0d", e.e_end, d[115:106]); errors++;
    end
    if (bad !== e.bad) begin
      $error("bad_request expected %b actual %b", e.bad, bad); errors++;
    end
  endfunction
endclass

module testbench;
  import cvg_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [119:0] m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  vertex_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  circle_vertex_generator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 8000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_segment(logic [9:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'd0, idx};
    do @(posedge clk); while (!s_tready);
    board.note(idx);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_circle(logic [31:0] v[7]);
    drain();
    for (int k = 0; k < 7; k++) begin
      cfg_valid <= 1;
      cfg_index <= reg_idx_t'(k);
      cfg_data <= v[k];
      do @(posedge clk); while (!cfg_ready);
      board.set_reg(k, v[k]);
    end
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(2000)) - 1000) << 16;
      2: return 32'(signed'($urandom_range(200)) - 100);
      default: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  logic [9:0] directed_idx[10] = '{0, 1, 24, 25, 50, 75, 99, 100, 512, 1023};
  logic [31:0] circ[7];

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed_idx[k]) send_segment(directed_idx[k]);
    // zero normal, normal near -z, zero radius, then extreme centre and radius
    circ = '{32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 0, 0, 0};
    load_circle(circ);
    for (int k = 0; k < 3; k++) send_segment(10'(k * 40));
    circ = '{32'h80000000, 32'h7fffffff, 32'h12345678, 32'hffffffff, 3, 32'hfffffffe,
             32'h80000000};
    load_circle(circ);
    for (int k = 0; k < 5; k++) send_segment(10'(k * 23));
    circ = '{0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h00010000};
    load_circle(circ);
    for (int k = 0; k < 4; k++) send_segment(10'(k * 31));
    circ = '{32'h7fff0000, 32'h80010000, 0, 32'h7fffffff, 0, 0, 32'h80000000};
    load_circle(circ);
    for (int k = 0; k < 4; k++) send_segment(10'(k * 30 + 7));
    for (int ph = 0; ph < 8; ph++) begin
      foreach (circ[k]) circ[k] = rand_coord();
      circ[REG_RADIUS] = ($urandom_range(1)) ? $urandom() : 32'($urandom_range(8)) << 16;
      if (ph == 5) circ[REG_NORMAL_X] = 0;
      if (ph == 5) circ[REG_NORMAL_Y] = 0;
      load_circle(circ);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 78; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 78; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < 160; n++) begin
        if (ph == 3 && n == 80) begin
          s_tvalid <= 0;
          while (board.pending_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(9) == 0) send_segment(10'($urandom_range(1023)));
        else send_segment(10'($urandom_range(SEGMENTS - 1)));
      end
    end
    s_tvalid <= 0;
    recv_stall_pct = 0;
    drain();
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
